### design/dfb_pkg.sv
// ----------------------------------------------------------------------------
// dfb_pkg
// shared types, codes and helpers of the directional flame blur
// ----------------------------------------------------------------------------
package dfb_pkg;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_PUPIL_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PUPIL_CENTER_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ARC_OFFSET     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ARC_RADIUS_SQ  = 2'd3;

    localparam logic [11:0] PUPIL_CENTER_X_RESET = 12'd1280;
    localparam logic [12:0] PUPIL_CENTER_Y_RESET = 13'd3840;
    localparam logic [11:0] ARC_OFFSET_RESET     = 12'd2184;
    localparam logic [23:0] ARC_RADIUS_SQ_RESET  = 24'd5019110;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [11:0] center_x;
        logic [12:0] center_y;
        logic [11:0] arc_offset;
        logic [23:0] radius_sq;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_ZERO,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  heat;
        logic [11:0] map;
        logic        in_pupil;
    } cmd_info_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DECODE,
        B_READ,
        B_TAIL,
        B_DIV3,
        B_SCALE,
        B_RECIP,
        B_FIX,
        B_DONE
    } back_state_t;

    // stored step field: binary 10 saturates to minus one
    function automatic logic signed [1:0] step_of(input logic [1:0] bits);
        logic signed [1:0] s;
        case (bits)
            2'b00:   s = 2'sd0;
            2'b01:   s = 2'sd1;
            default: s = -2'sd1;
        endcase
        return s;
    endfunction

endpackage

### design/dfb_queue.sv
// ----------------------------------------------------------------------------
// dfb_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module dfb_queue #(
    parameter int DATA_W = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = $clog2(dfb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dfb_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(dfb_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C = PTR_W'(dfb_pkg::QUEUE_DEPTH - 1);

    logic [DATA_W-1:0] slot_reg [dfb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != FULL_C);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/dfb_front.sv
// ----------------------------------------------------------------------------
// dfb_front
// takes input words, works out frame index, border and pupil, queues commands
// ----------------------------------------------------------------------------
module dfb_front #(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 480,
    parameter int IDX_W        = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dfb_pkg::cfg_t           cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic [7:0]              column,
    input  logic [8:0]              row,
    input  logic [7:0]              heat_value,
    input  logic signed [1:0]       step_x,
    input  logic signed [1:0]       step_y,
    input  logic [7:0]              edge_distance,
    output logic                    push_valid,
    input  logic                    push_ready,
    output dfb_pkg::cmd_info_t      push_info,
    output logic [IDX_W-1:0]        push_idx
);

    dfb_pkg::front_state_t state_reg;
    dfb_pkg::front_state_t state_next;

    logic              op_reg;
    logic [7:0]        column_reg;
    logic [8:0]        row_reg;
    logic [7:0]        heat_reg;
    logic [11:0]       map_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [27:0]       a2_reg;
    logic [27:0]       b2_reg;
    logic [27:0]       dy2_reg;

    logic              accept;
    logic [14:0]       x16;
    logic [14:0]       y16;
    logic signed [14:0] arc_a;
    logic signed [14:0] arc_b;
    logic signed [14:0] dy;
    logic signed [29:0] a2_full;
    logic signed [29:0] b2_full;
    logic signed [29:0] dy2_full;
    logic [IDX_W-1:0]  idx_next;
    logic [28:0]       sum_a;
    logic [28:0]       sum_b;
    logic              in_pupil;
    logic              in_frame;
    logic              border;
    logic              drop;

    assign accept = in_valid && in_ready;

    // pupil geometry in sixteenths of a pixel
    assign x16      = {3'b000, column_reg, 4'b0000};
    assign y16      = {2'b00, row_reg, 4'b0000};
    assign arc_a    = signed'(x16 - {3'b000, cfg.center_x} + {3'b000, cfg.arc_offset});
    assign arc_b    = signed'(x16 - {3'b000, cfg.center_x} - {3'b000, cfg.arc_offset});
    assign dy       = signed'(y16 - {2'b00, cfg.center_y});
    assign a2_full  = arc_a * arc_a;
    assign b2_full  = arc_b * arc_b;
    assign dy2_full = dy * dy;
    assign idx_next = IDX_W'(32'(row_reg) * FRAME_WIDTH + 32'(column_reg));

    assign sum_a    = 29'(a2_reg) + 29'(dy2_reg);
    assign sum_b    = 29'(b2_reg) + 29'(dy2_reg);
    assign in_pupil = (sum_a <= 29'(cfg.radius_sq)) && (sum_b <= 29'(cfg.radius_sq));

    assign in_frame = (32'(column_reg) < FRAME_WIDTH) && (32'(row_reg) < FRAME_HEIGHT);
    assign border   = (column_reg == '0) || (32'(column_reg) >= FRAME_WIDTH - 1)
                   || (row_reg == '0) || (32'(row_reg) >= FRAME_HEIGHT - 1);
    assign drop     = (op_reg == dfb_pkg::OP_LOAD) && !in_frame;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dfb_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = dfb_pkg::F_CALC;
                end
            end
            dfb_pkg::F_CALC:
            begin
                state_next = dfb_pkg::F_PUSH;
            end
            dfb_pkg::F_PUSH:
            begin
                if (drop || push_ready)
                begin
                    state_next = dfb_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = dfb_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            dfb_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
            end
            dfb_pkg::F_CALC:
            begin
                in_ready = 1'b0;
            end
            dfb_pkg::F_PUSH:
            begin
                push_valid = !drop;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        push_info.heat     = heat_reg;
        push_info.map      = map_reg;
        push_info.in_pupil = in_pupil;
        if (op_reg == dfb_pkg::OP_LOAD)
        begin
            push_info.kind = dfb_pkg::CMD_LOAD;
        end
        else if (border)
        begin
            push_info.kind = dfb_pkg::CMD_ZERO;
        end
        else
        begin
            push_info.kind = dfb_pkg::CMD_COMPUTE;
        end
    end

    assign push_idx = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dfb_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            column_reg <= column;
            row_reg    <= row;
            heat_reg   <= heat_value;
            map_reg    <= {edge_distance, step_y, step_x};
        end
        if (state_reg == dfb_pkg::F_CALC)
        begin
            idx_reg <= idx_next;
            a2_reg  <= a2_full[27:0];
            b2_reg  <= b2_full[27:0];
            dy2_reg <= dy2_full[27:0];
        end
    end

endmodule

### design/dfb_back.sv
// ----------------------------------------------------------------------------
// dfb_back
// frame memories and the sequencer that carries out queued commands
// ----------------------------------------------------------------------------
module dfb_back #(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 480,
    parameter int REACH        = 16,
    parameter int IDX_W        = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  dfb_pkg::cmd_info_t      pop_info,
    input  logic [IDX_W-1:0]        pop_idx,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              result_heat
);

    localparam int FRAME_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW         = IDX_W + 3;
    localparam int RECIP      = 65536 / REACH;

    localparam logic [16:0]          RECIP_C = 17'(RECIP);
    localparam logic [7:0]           REACH_C = 8'(REACH);
    localparam logic signed [AW-1:0] FW_S    = AW'(FRAME_WIDTH);
    localparam logic signed [AW-1:0] LAST_S  = AW'(FRAME_SIZE - 1);
    localparam logic [IDX_W-1:0]     LAST_C  = IDX_W'(FRAME_SIZE - 1);

    logic [7:0]  heat_mem [FRAME_SIZE];
    logic [11:0] map_mem  [FRAME_SIZE];

    dfb_pkg::back_state_t state_reg;
    dfb_pkg::back_state_t state_next;

    logic [7:0]        heat_rd_reg;
    logic [11:0]       map_rd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              pupil_reg;
    logic              avg_reg;
    logic              avg_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              pend_reg;
    logic              pend_next;
    logic [9:0]        acc_reg;
    logic [9:0]        acc_next;
    logic [7:0]        q3_reg;
    logic [15:0]       prod_reg;
    logic [15:0]       qe_reg;
    logic [7:0]        res_reg;
    logic [7:0]        res_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        result_heat_reg;

    logic              heat_we;
    logic              heat_re;
    logic              map_re;
    logic [IDX_W-1:0]  heat_addr;

    logic signed [1:0] sx;
    logic signed [1:0] sy;
    logic [7:0]        edge_dist;
    logic              step_zero;
    logic              too_far;
    logic [1:0]        last_cnt;
    logic signed [2:0] row_off;
    logic signed [2:0] col_off;
    logic signed [AW-1:0] addr_s;
    logic [IDX_W-1:0]  rd_addr;
    logic [9:0]        total;
    logic [19:0]       div3_full;
    logic [15:0]       scale_full;
    logic [32:0]       recip_full;
    logic [23:0]       back_full;
    logic [16:0]       rem;
    logic [15:0]       fixq;
    logic              load_out;

    assign sx        = dfb_pkg::step_of(map_rd_reg[1:0]);
    assign sy        = dfb_pkg::step_of(map_rd_reg[3:2]);
    assign edge_dist = map_rd_reg[11:4];
    assign step_zero = (sx == 2'sd0) && (sy == 2'sd0);
    assign too_far   = (edge_dist > REACH_C);
    assign last_cnt  = avg_reg ? 2'd3 : 2'd2;
    assign load_out  = (state_reg == dfb_pkg::B_DONE) && (!out_valid_reg || out_ready);

    // neighbour offsets: four-neighbour average, or the step and the two offsets either side of it
    always_comb
    begin
        row_off = 3'sd0;
        col_off = 3'sd0;
        if (avg_reg)
        begin
            case (cnt_reg)
                2'd0:    col_off = -3'sd1;
                2'd1:    col_off = 3'sd1;
                2'd2:    row_off = -3'sd1;
                default: row_off = 3'sd1;
            endcase
        end
        else
        begin
            case (cnt_reg)
                2'd1:
                begin
                    row_off = 3'(sy) + 3'(sx);
                    col_off = 3'(sx) - 3'(sy);
                end
                2'd2:
                begin
                    row_off = 3'(sy) - 3'(sx);
                    col_off = 3'(sx) + 3'(sy);
                end
                default:
                begin
                    row_off = 3'(sy);
                    col_off = 3'(sx);
                end
            endcase
        end
    end

    assign addr_s = signed'({3'b000, idx_reg}) + AW'(row_off) * FW_S + AW'(col_off);

    always_comb
    begin
        if (addr_s[AW-1])
        begin
            rd_addr = '0;
        end
        else if (addr_s > LAST_S)
        begin
            rd_addr = LAST_C;
        end
        else
        begin
            rd_addr = addr_s[IDX_W-1:0];
        end
    end

    assign total      = acc_reg + 10'(heat_rd_reg);
    assign div3_full  = 20'(acc_reg) * 20'd683;
    assign scale_full = 16'(q3_reg) * 16'(REACH_C - edge_dist);
    assign recip_full = 33'(prod_reg) * 33'(RECIP_C);
    assign back_full  = 24'(qe_reg) * 24'(REACH_C);
    assign rem        = 17'(prod_reg) - back_full[16:0];
    assign fixq       = qe_reg + 16'(rem >= 17'(REACH_C));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dfb_pkg::B_IDLE:
            begin
                if (pop_valid)
                begin
                    unique case (pop_info.kind)
                        dfb_pkg::CMD_ZERO:    state_next = dfb_pkg::B_DONE;
                        dfb_pkg::CMD_COMPUTE: state_next = dfb_pkg::B_DECODE;
                        default:              state_next = dfb_pkg::B_IDLE;
                    endcase
                end
            end
            dfb_pkg::B_DECODE:
            begin
                if (step_zero ? pupil_reg : too_far)
                begin
                    state_next = dfb_pkg::B_DONE;
                end
                else
                begin
                    state_next = dfb_pkg::B_READ;
                end
            end
            dfb_pkg::B_READ:
            begin
                if (cnt_reg == last_cnt)
                begin
                    state_next = dfb_pkg::B_TAIL;
                end
            end
            dfb_pkg::B_TAIL:
            begin
                state_next = avg_reg ? dfb_pkg::B_DONE : dfb_pkg::B_DIV3;
            end
            dfb_pkg::B_DIV3:  state_next = dfb_pkg::B_SCALE;
            dfb_pkg::B_SCALE: state_next = dfb_pkg::B_RECIP;
            dfb_pkg::B_RECIP: state_next = dfb_pkg::B_FIX;
            dfb_pkg::B_FIX:   state_next = dfb_pkg::B_DONE;
            dfb_pkg::B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = dfb_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = dfb_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        heat_we   = 1'b0;
        heat_re   = 1'b0;
        map_re    = 1'b0;
        heat_addr = pop_idx;
        avg_next  = avg_reg;
        cnt_next  = cnt_reg;
        pend_next = 1'b0;
        acc_next  = acc_reg;
        res_next  = res_reg;
        unique case (state_reg)
            dfb_pkg::B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    heat_we  = (pop_info.kind == dfb_pkg::CMD_LOAD);
                    map_re   = (pop_info.kind == dfb_pkg::CMD_COMPUTE);
                    res_next = '0;
                end
            end
            dfb_pkg::B_DECODE:
            begin
                avg_next = step_zero;
                cnt_next = '0;
                acc_next = '0;
                res_next = '0;
            end
            dfb_pkg::B_READ:
            begin
                heat_re   = 1'b1;
                heat_addr = rd_addr;
                pend_next = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (pend_reg)
                begin
                    acc_next = total;
                end
            end
            dfb_pkg::B_TAIL:
            begin
                acc_next = total;
                res_next = total[9:2];
            end
            dfb_pkg::B_FIX:
            begin
                res_next = (fixq == '0) ? 8'd0 : fixq[7:0] - 8'd1;
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_heat = result_heat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dfb_pkg::B_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg <= avg_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        if (state_reg == dfb_pkg::B_IDLE)
        begin
            idx_reg   <= pop_idx;
            pupil_reg <= pop_info.in_pupil;
        end
        if (state_reg == dfb_pkg::B_DIV3)
        begin
            q3_reg <= div3_full[18:11];
        end
        if (state_reg == dfb_pkg::B_SCALE)
        begin
            prod_reg <= scale_full;
        end
        if (state_reg == dfb_pkg::B_RECIP)
        begin
            qe_reg <= recip_full[31:16];
        end
        if (load_out)
        begin
            result_heat_reg <= res_reg;
        end
    end

    // single port heat frame
    always_ff @(posedge clk)
    begin
        if (heat_we)
        begin
            heat_mem[heat_addr] <= pop_info.heat;
        end
        else if (heat_re)
        begin
            heat_rd_reg <= heat_mem[heat_addr];
        end
    end

    // step and edge distance map
    always_ff @(posedge clk)
    begin
        if (heat_we)
        begin
            map_mem[pop_idx] <= pop_info.map;
        end
        else if (map_re)
        begin
            map_rd_reg <= map_mem[pop_idx];
        end
    end

endmodule

### design/directional_flame_blur.sv
// ----------------------------------------------------------------------------
// directional_flame_blur
// next-frame flame heat from a stored heat frame and inward step map
// ----------------------------------------------------------------------------
// In-frame load words write one pixel's heat and map entry and give no result;
// compute words give one result each, in order. The front takes one word at a
// time (accept, then the index and pupil products, then a push that waits for
// queue space) and queues it; a two-entry queue lets it run ahead of the back.
// The back sequencer drives the single-port heat memory and the slower of the
// two sets the sustained rate: the back handles a load, a border zero, a pupil
// or beyond-reach zero, the four-neighbour average (four heat reads) and the
// directional blur (three heat reads, then divide by three, scale, reciprocal
// multiply and correction, in that order), so for loads and border words the
// front sets the rate. A result held by a low out_ready stalls the back.
// Entries are undefined until written; no clearing pass is run after reset.
module directional_flame_blur #(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 480,
    parameter int REACH        = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_enable,
    input  logic [dfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dfb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [7:0]                        column,
    input  logic [8:0]                        row,
    input  logic [7:0]                        heat_value,
    input  logic signed [1:0]                 step_x,
    input  logic signed [1:0]                 step_y,
    input  logic [7:0]                        edge_distance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        result_heat
);

    localparam int IDX_W  = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
    localparam int CMD_W  = $bits(dfb_pkg::cmd_info_t) + IDX_W;

    dfb_pkg::cfg_t      cfg_reg;
    dfb_pkg::cfg_t      cfg_next;

    logic               push_valid;
    logic               push_ready;
    dfb_pkg::cmd_info_t push_info;
    logic [IDX_W-1:0]   push_idx;
    logic               pop_valid;
    logic               pop_ready;
    logic [CMD_W-1:0]   pop_data;
    dfb_pkg::cmd_info_t pop_info;
    logic [IDX_W-1:0]   pop_idx;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_enable)
        begin
            unique case (cfg_index)
                dfb_pkg::REG_PUPIL_CENTER_X: cfg_next.center_x   = cfg_data[11:0];
                dfb_pkg::REG_PUPIL_CENTER_Y: cfg_next.center_y   = cfg_data[12:0];
                dfb_pkg::REG_ARC_OFFSET:     cfg_next.arc_offset = cfg_data[11:0];
                dfb_pkg::REG_ARC_RADIUS_SQ:  cfg_next.radius_sq  = cfg_data[23:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x   <= dfb_pkg::PUPIL_CENTER_X_RESET;
            cfg_reg.center_y   <= dfb_pkg::PUPIL_CENTER_Y_RESET;
            cfg_reg.arc_offset <= dfb_pkg::ARC_OFFSET_RESET;
            cfg_reg.radius_sq  <= dfb_pkg::ARC_RADIUS_SQ_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dfb_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .IDX_W        (IDX_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .column        (column),
        .row           (row),
        .heat_value    (heat_value),
        .step_x        (step_x),
        .step_y        (step_y),
        .edge_distance (edge_distance),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_info     (push_info),
        .push_idx      (push_idx)
    );

    dfb_queue #(
        .DATA_W (CMD_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_info, push_idx}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_info = pop_data[CMD_W-1:IDX_W];
    assign pop_idx  = pop_data[IDX_W-1:0];

    dfb_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .REACH        (REACH),
        .IDX_W        (IDX_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_info    (pop_info),
        .pop_idx     (pop_idx),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_heat (result_heat)
    );

    // front works on one word at a time
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("front took a word while busy");

    // a queued command stalled by a full queue is held
    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> (push_valid && $stable(push_idx)))
        else $error("queued command dropped while queue full");

    // radius write lands in the register
    a_cfg_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write_enable && (cfg_index == dfb_pkg::REG_ARC_RADIUS_SQ))
        |=> (cfg_reg.radius_sq == $past(cfg_data[23:0])))
        else $error("arc radius write lost");

endmodule
